### rtl/hypotrochoid_point_generator_assert.svh
// assertion macros for the hypotrochoid point generator
`ifndef HYPOTROCHOID_POINT_GENERATOR_ASSERT_SVH
`define HYPOTROCHOID_POINT_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define HPG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HPG_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HPG_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define HPG_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### rtl/hpg_pkg.sv
`timescale 1ns / 1ps
package hpg_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_BITS = 16;
    localparam int PHASE_FRACTION_BITS = 24;
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_INDEX_BITS = 2;
    // phase divider: one quotient bit per cell
    localparam int DIV_CELLS = PHASE_FRACTION_BITS;
    localparam int NUM1_BITS = 24;   // idx*rot
    localparam int DEN1_BITS = 16;
    localparam int NUM2_BITS = 41;   // idx*rot*k1
    localparam int DEN2_BITS = 33;   // cnt*k
    // front stages, remainder cells, fraction cells, cordic cells, product and output
    localparam int PIPE_DEPTH = 3 + NUM2_BITS + DIV_CELLS + CORDIC_STAGES + 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ARM_RATIO    = 2'd0,
        REG_RADIUS_RATIO = 2'd1,
        REG_ROTATIONS    = 2'd2,
        REG_POINT_COUNT  = 2'd3
    } t_reg_index;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    typedef struct packed {
        logic              valid;
        logic              beyond;
        logic [16:0]       k1;
        logic [33:0]       lk;
    } t_side;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_rot;

    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] v;
        case (i)
            0: v = 34'sd536870912;  1: v = 34'sd316933406;
            2: v = 34'sd167458907;  3: v = 34'sd85004756;
            4: v = 34'sd42667331;   5: v = 34'sd21354465;
            6: v = 34'sd10679838;   7: v = 34'sd5340245;
            8: v = 34'sd2670163;    9: v = 34'sd1335087;
            10: v = 34'sd667544;    11: v = 34'sd333772;
            12: v = 34'sd166886;    13: v = 34'sd83443;
            14: v = 34'sd41722;     15: v = 34'sd20861;
            16: v = 34'sd10430;     17: v = 34'sd5215;
            18: v = 34'sd2608;      19: v = 34'sd1304;
            20: v = 34'sd652;       21: v = 34'sd326;
            22: v = 34'sd163;       23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

### rtl/hpg_div_cell.sv
`timescale 1ns / 1ps
// one restoring-division step for both phases, passes side data along
module hpg_div_cell (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [hpg_pkg::DEN1_BITS-1:0]    i_r1,
    input  logic [hpg_pkg::DEN1_BITS-1:0]    i_d1,
    input  logic [hpg_pkg::DEN2_BITS-1:0]    i_r2,
    input  logic [hpg_pkg::DEN2_BITS-1:0]    i_d2,
    input  logic [hpg_pkg::PHASE_FRACTION_BITS-1:0] i_f1,
    input  logic [hpg_pkg::PHASE_FRACTION_BITS-1:0] i_f2,
    input  hpg_pkg::t_side                   i_side,
    output logic [hpg_pkg::DEN1_BITS-1:0]    o_r1,
    output logic [hpg_pkg::DEN1_BITS-1:0]    o_d1,
    output logic [hpg_pkg::DEN2_BITS-1:0]    o_r2,
    output logic [hpg_pkg::DEN2_BITS-1:0]    o_d2,
    output logic [hpg_pkg::PHASE_FRACTION_BITS-1:0] o_f1,
    output logic [hpg_pkg::PHASE_FRACTION_BITS-1:0] o_f2,
    output hpg_pkg::t_side                   o_side
);
    import hpg_pkg::*;
    logic [DEN1_BITS:0] n_s1;
    logic [DEN2_BITS:0] n_s2;
    logic               n_b1, n_b2;
    logic [DEN1_BITS-1:0] n_r1;
    logic [DEN2_BITS-1:0] n_r2;

    always_comb begin
        n_s1 = {i_r1, 1'b0};
        n_b1 = n_s1 >= {1'b0, i_d1};
        n_r1 = n_b1 ? DEN1_BITS'(n_s1 - {1'b0, i_d1}) : DEN1_BITS'(n_s1);
        n_s2 = {i_r2, 1'b0};
        n_b2 = n_s2 >= {1'b0, i_d2};
        n_r2 = n_b2 ? DEN2_BITS'(n_s2 - {1'b0, i_d2}) : DEN2_BITS'(n_s2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r1   <= n_r1;
            o_d1   <= i_d1;
            o_r2   <= n_r2;
            o_d2   <= i_d2;
            o_f1   <= {i_f1[PHASE_FRACTION_BITS-2:0], n_b1};
            o_f2   <= {i_f2[PHASE_FRACTION_BITS-2:0], n_b2};
            o_side <= i_side;
        end
    end
endmodule

### rtl/hpg_cordic_cell.sv
`timescale 1ns / 1ps
// one micro-rotation of both cordics
module hpg_cordic_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [4:0]     i_shift,
    input  hpg_pkg::t_rot  i_a,
    input  hpg_pkg::t_rot  i_b,
    input  logic [3:0]     i_quad,
    input  hpg_pkg::t_side i_side,
    output hpg_pkg::t_rot  o_a,
    output hpg_pkg::t_rot  o_b,
    output logic [3:0]     o_quad,
    output hpg_pkg::t_side o_side
);
    import hpg_pkg::*;

    function automatic t_rot step(input t_rot v, input logic [4:0] sh);
        t_rot r;
        logic signed [33:0] dx, dy, at;
        dx = v.y >>> sh;
        dy = v.x >>> sh;
        at = atan_turn(int'(sh));
        if (!v.z[33]) begin
            r.x = v.x - dx; r.y = v.y + dy; r.z = v.z - at;
        end else begin
            r.x = v.x + dx; r.y = v.y - dy; r.z = v.z + at;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_a    <= step(i_a, i_shift);
            o_b    <= step(i_b, i_shift);
            o_quad <= i_quad;
            o_side <= i_side;
        end
    end
endmodule

### rtl/hypotrochoid_point_generator.sv
`timescale 1ns / 1ps
// channel  | handshake                     | payload
// input    | i_valid / o_ready             | i_point_index
// output   | o_valid / i_ready             | o_x_coord, o_y_coord, o_index_beyond_count
// config   | i_cfg_we                      | i_cfg_index, i_cfg_data
// one item per cycle unless the output stalls; pipeline: 3 front stages, 41 remainder
// cells, 24 fraction cells, 16 cordic cells, product and output registers
// the whole pipeline advances when the output register is empty or being taken
// a stall on the output freezes every cell; ready falls only under that stall
// reset (synchronous, active low) clears valid bits and loads register defaults
module hypotrochoid_point_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [15:0]                        i_point_index,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [hpg_pkg::COORD_BITS-1:0] o_x_coord,
    output logic signed [hpg_pkg::COORD_BITS-1:0] o_y_coord,
    output logic                               o_index_beyond_count,
    input  logic                               i_cfg_we,
    input  logic [hpg_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [hpg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import hpg_pkg::*;
`include "hypotrochoid_point_generator_assert.svh"

    logic [16:0] r_arm, r_rad;
    logic [7:0]  r_rot;
    logic [15:0] r_cnt;
    logic        w_en;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm <= 17'd19661; r_rad <= 17'd49152;
            r_rot <= 8'd10;     r_cnt <= 16'd500;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_ARM_RATIO:    r_arm <= i_cfg_data;
                REG_RADIUS_RATIO: r_rad <= i_cfg_data;
                REG_ROTATIONS:    r_rot <= i_cfg_data[7:0];
                REG_POINT_COUNT:  r_cnt <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front stage 1: clamp ratios, compare index
    logic [16:0] r_l1, r_k1s, r_km1;
    logic [15:0] r_idx1, r_cnt1;
    logic [7:0]  r_rot1;
    logic        r_v1, r_beyond1;
    logic [16:0] n_l, n_k;
    always_comb begin
        n_l = r_arm > 17'd65536 ? 17'd65536 : r_arm;
        n_k = r_rad > 17'd65536 ? 17'd65536 : r_rad;
        if (n_k == 17'd0) n_k = 17'd1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= i_valid;
        if (w_en) begin
            r_l1 <= n_l; r_k1s <= n_k; r_km1 <= 17'(17'd65536 - n_k);
            r_idx1 <= i_point_index; r_cnt1 <= r_cnt; r_rot1 <= r_rot;
            r_beyond1 <= i_point_index >= r_cnt;
        end
    end

    // stage 2: base = idx*rot, den2 = cnt*k, lk = l*k
    logic [NUM1_BITS-1:0] r_base2;
    logic [DEN2_BITS-1:0] r_den2;
    logic [15:0] r_cnt2;
    logic [16:0] r_km2;
    t_side       r_side2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_side2.valid <= 1'b0;
        else if (w_en) r_side2.valid <= r_v1;
        if (w_en) begin
            r_base2 <= NUM1_BITS'(r_idx1) * NUM1_BITS'(r_rot1);
            r_den2  <= DEN2_BITS'(r_cnt1) * DEN2_BITS'(r_k1s);
            r_cnt2  <= r_cnt1;
            r_km2   <= r_km1;
            r_side2.beyond <= r_beyond1;
            r_side2.k1     <= r_km1;
            r_side2.lk     <= 34'(r_l1) * 34'(r_k1s);
        end
    end

    // stage 3: num2 = base*k1
    logic [NUM2_BITS-1:0] r_num3;
    logic [NUM1_BITS-1:0] r_base3;
    logic [DEN2_BITS-1:0] r_den3;
    logic [15:0] r_cnt3;
    t_side       r_side3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_side3.valid <= 1'b0;
        else if (w_en) r_side3.valid <= r_side2.valid;
        if (w_en) begin
            r_num3  <= NUM2_BITS'(r_base2) * NUM2_BITS'(r_km2);
            r_base3 <= r_base2;
            r_den3  <= r_den2;
            r_cnt3  <= r_cnt2;
            r_side3.beyond <= r_side2.beyond;
            r_side3.k1     <= r_side2.k1;
            r_side3.lk     <= r_side2.lk;
        end
    end

    // integer-part reduction: a chain of cells over the numerator bits,
    // one bit per cell, shifting the remainder; fraction bits then follow.
    // integer chain for both numerators runs NUM2_BITS cells long
    localparam int INT_CELLS = NUM2_BITS;
    logic [DEN1_BITS-1:0] w_ir1 [INT_CELLS+1];
    logic [DEN2_BITS-1:0] w_ir2 [INT_CELLS+1];
    logic [NUM2_BITS-1:0] w_in2 [INT_CELLS+1];
    logic [NUM2_BITS-1:0] w_in1 [INT_CELLS+1];
    logic [DEN1_BITS-1:0] w_id1 [INT_CELLS+1];
    logic [DEN2_BITS-1:0] w_id2 [INT_CELLS+1];
    t_side                w_is  [INT_CELLS+1];
    assign w_ir1[0] = '0;
    assign w_ir2[0] = '0;
    assign w_in1[0] = NUM2_BITS'(r_base3);
    assign w_in2[0] = r_num3;
    assign w_id1[0] = r_cnt3;
    assign w_id2[0] = r_den3;
    assign w_is[0]  = r_side3;

    for (genvar g = 0; g < INT_CELLS; g++) begin : g_int
        logic [DEN1_BITS:0] s1;
        logic [DEN2_BITS:0] s2;
        logic [DEN1_BITS-1:0] rr1;
        logic [DEN2_BITS-1:0] rr2;
        logic [DEN1_BITS-1:0] q_r1;
        logic [DEN2_BITS-1:0] q_r2;
        logic [NUM2_BITS-1:0] q_n1, q_n2;
        logic [DEN1_BITS-1:0] q_d1;
        logic [DEN2_BITS-1:0] q_d2;
        t_side q_s;
        always_comb begin
            s1 = {w_ir1[g], w_in1[g][NUM2_BITS-1]};
            s2 = {w_ir2[g], w_in2[g][NUM2_BITS-1]};
            rr1 = (s1 >= {1'b0, w_id1[g]}) ? DEN1_BITS'(s1 - {1'b0, w_id1[g]})
                                          : DEN1_BITS'(s1);
            rr2 = (s2 >= {1'b0, w_id2[g]}) ? DEN2_BITS'(s2 - {1'b0, w_id2[g]})
                                          : DEN2_BITS'(s2);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) q_s.valid <= 1'b0;
            else if (w_en) q_s.valid <= w_is[g].valid;
            if (w_en) begin
                q_r1 <= rr1; q_r2 <= rr2;
                q_n1 <= {w_in1[g][NUM2_BITS-2:0], 1'b0};
                q_n2 <= {w_in2[g][NUM2_BITS-2:0], 1'b0};
                q_d1 <= w_id1[g]; q_d2 <= w_id2[g];
                q_s.beyond <= w_is[g].beyond;
                q_s.k1 <= w_is[g].k1;
                q_s.lk <= w_is[g].lk;
            end
        end
        assign w_ir1[g+1] = q_r1;
        assign w_ir2[g+1] = q_r2;
        assign w_in1[g+1] = q_n1;
        assign w_in2[g+1] = q_n2;
        assign w_id1[g+1] = q_d1;
        assign w_id2[g+1] = q_d2;
        assign w_is[g+1]  = q_s;
    end

    // fraction cells
    logic [DEN1_BITS-1:0] w_r1 [DIV_CELLS+1];
    logic [DEN1_BITS-1:0] w_d1 [DIV_CELLS+1];
    logic [DEN2_BITS-1:0] w_r2 [DIV_CELLS+1];
    logic [DEN2_BITS-1:0] w_d2 [DIV_CELLS+1];
    logic [PHASE_FRACTION_BITS-1:0] w_f1 [DIV_CELLS+1];
    logic [PHASE_FRACTION_BITS-1:0] w_f2 [DIV_CELLS+1];
    t_side w_dsv [DIV_CELLS+1];
    assign w_r1[0] = w_ir1[INT_CELLS];
    assign w_r2[0] = w_ir2[INT_CELLS];
    assign w_d1[0] = w_id1[INT_CELLS];
    assign w_d2[0] = w_id2[INT_CELLS];
    assign w_f1[0] = '0;
    assign w_f2[0] = '0;
    assign w_dsv[0] = w_is[INT_CELLS];

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        logic r_v;
        t_side s_o;
        hpg_div_cell u_cell (
            .i_clk(i_clk), .i_en(w_en),
            .i_r1(w_r1[g]), .i_d1(w_d1[g]), .i_r2(w_r2[g]), .i_d2(w_d2[g]),
            .i_f1(w_f1[g]), .i_f2(w_f2[g]), .i_side(w_dsv[g]),
            .o_r1(w_r1[g+1]), .o_d1(w_d1[g+1]), .o_r2(w_r2[g+1]), .o_d2(w_d2[g+1]),
            .o_f1(w_f1[g+1]), .o_f2(w_f2[g+1]), .o_side(s_o)
        );
        // valid bit kept under reset beside the cell
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v <= 1'b0;
            else if (w_en) r_v <= w_dsv[g].valid;
        end
        assign w_dsv[g+1] = {r_v, s_o.beyond, s_o.k1, s_o.lk};
    end

    // cordic load: quadrant split of both phases
    t_rot  w_ra [CORDIC_STAGES+1];
    t_rot  w_rb [CORDIC_STAGES+1];
    logic [3:0] w_q [CORDIC_STAGES+1];
    t_side w_cs [CORDIC_STAGES+1];
    logic [31:0] w_p1, w_p2;
    assign w_p1 = 32'(w_f1[DIV_CELLS]) << (32 - PHASE_FRACTION_BITS);
    assign w_p2 = 32'(w_f2[DIV_CELLS]) << (32 - PHASE_FRACTION_BITS);
    assign w_ra[0] = '{x: CORDIC_START, y: '0, z: {4'b0, w_p1[29:0]}};
    assign w_rb[0] = '{x: CORDIC_START, y: '0, z: {4'b0, w_p2[29:0]}};
    assign w_q[0]  = {w_p1[31:30], w_p2[31:30]};
    assign w_cs[0] = w_dsv[DIV_CELLS];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
        logic  r_v;
        t_side s_o;
        hpg_cordic_cell u_cell (
            .i_clk(i_clk), .i_en(w_en), .i_shift(5'(g)),
            .i_a(w_ra[g]), .i_b(w_rb[g]), .i_quad(w_q[g]), .i_side(w_cs[g]),
            .o_a(w_ra[g+1]), .o_b(w_rb[g+1]), .o_quad(w_q[g+1]), .o_side(s_o)
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v <= 1'b0;
            else if (w_en) r_v <= w_cs[g].valid;
        end
        assign w_cs[g+1] = {r_v, s_o.beyond, s_o.k1, s_o.lk};
    end

    // quadrant fold
    function automatic void fold(input t_rot v, input logic [1:0] q,
                                 output logic signed [33:0] c,
                                 output logic signed [33:0] s);
        case (q)
            2'd1: begin c = -v.y; s = v.x;  end
            2'd2: begin c = -v.x; s = -v.y; end
            2'd3: begin c = v.y;  s = -v.x; end
            default: begin c = v.x; s = v.y; end
        endcase
    endfunction

    logic signed [33:0] n_c1, n_s1, n_c2, n_s2;
    always_comb begin
        fold(w_ra[CORDIC_STAGES], w_q[CORDIC_STAGES][3:2], n_c1, n_s1);
        fold(w_rb[CORDIC_STAGES], w_q[CORDIC_STAGES][1:0], n_c2, n_s2);
    end

    // product stage
    logic signed [51:0] r_px1, r_py1;
    logic signed [67:0] r_px2, r_py2;
    logic               r_vp, r_bp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vp <= 1'b0;
        else if (w_en) r_vp <= w_cs[CORDIC_STAGES].valid;
        if (w_en) begin
            r_bp  <= w_cs[CORDIC_STAGES].beyond;
            r_px1 <= 52'(n_c1) * 52'($signed({1'b0, w_cs[CORDIC_STAGES].k1}));
            r_py1 <= 52'(n_s1) * 52'($signed({1'b0, w_cs[CORDIC_STAGES].k1}));
            r_px2 <= 68'(n_c2) * 68'($signed({1'b0, w_cs[CORDIC_STAGES].lk}));
            r_py2 <= 68'(n_s2) * 68'($signed({1'b0, w_cs[CORDIC_STAGES].lk}));
        end
    end

    // sum, round, saturate; beyond-count items forced to zero
    localparam int SH = 63 - COORD_BITS;
    logic signed [69:0] n_xs, n_ys, n_xr, n_yr;
    logic signed [COORD_BITS-1:0] n_x, n_y;
    localparam logic signed [69:0] HI = 70'sd2 ** (COORD_BITS - 1) - 70'sd1;
    localparam logic signed [69:0] LO = -HI - 70'sd1;
    always_comb begin
        n_xs = (70'(r_px1) <<< 16) + 70'(r_px2);
        n_ys = (70'(r_py1) <<< 16) - 70'(r_py2);
        n_xr = (n_xs + (70'sd1 <<< (SH - 1))) >>> SH;
        n_yr = (n_ys + (70'sd1 <<< (SH - 1))) >>> SH;
        n_x = n_xr > HI ? COORD_BITS'(HI) : (n_xr < LO ? COORD_BITS'(LO)
                                                   : COORD_BITS'(n_xr));
        n_y = n_yr > HI ? COORD_BITS'(HI) : (n_yr < LO ? COORD_BITS'(LO)
                                                   : COORD_BITS'(n_yr));
        if (r_bp) begin n_x = '0; n_y = '0; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (w_en) o_valid <= r_vp;
        if (w_en) begin
            o_x_coord <= n_x;
            o_y_coord <= n_y;
            o_index_beyond_count <= r_bp;
        end
    end

    `HPG_ASSERT_CLK(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid,
        "result dropped under stall")
    `HPG_ASSERT_CLK(a_ready, i_clk, i_rst_n, !o_valid |-> o_ready,
        "ready low with empty output")
    `HPG_ASSERT_CLK(a_beyond, i_clk, i_rst_n,
        (o_valid && o_index_beyond_count) |-> (o_x_coord == '0 && o_y_coord == '0),
        "flagged item with nonzero coordinates")
    `HPG_ASSERT_NORST(a_rst, i_clk, !$past(i_rst_n) |-> !o_valid,
        "valid after reset")
endmodule

### verif/hypotrochoid_point_generator_test.sv
`timescale 1ns / 1ps
module hypotrochoid_point_generator_test;
    import hpg_pkg::*;

    localparam int LATENCY = PIPE_DEPTH + 4;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               beyond;
    } t_point;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [15:0]        i_point_index;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_x_coord;
    logic signed [15:0] o_y_coord;
    logic               o_index_beyond_count;
    logic               i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    hypotrochoid_point_generator dut (.*);

    // shadow copy of the set-up registers
    logic [16:0] arm_q16;
    logic [16:0] radius_q16;
    logic [7:0]  turn_count;
    logic [15:0] figure_points;

    t_point pending_points[$];
    int     mismatch_count;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;
    bit     timed_out;

    longint atan_tab[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint shift_right(longint v, int s);
        return v >>> s;
    endfunction

    // truncated fraction of a turn, 24 bits
    function automatic longint turn_fraction(longint unsigned num, longint unsigned den);
        longint unsigned r;
        longint unsigned f;
        r = num % den;
        f = 0;
        for (int i = 0; i < PHASE_FRACTION_BITS; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= den) begin
                r -= den;
                f |= 1;
            end
        end
        return longint'(f);
    endfunction

    task automatic rotate_phase(input longint phase, output longint c, output longint s);
        logic [31:0] p32;
        longint x, y, z, dx, dy, t;
        p32 = 32'(phase << (32 - PHASE_FRACTION_BITS));
        z = longint'(p32[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = shift_right(y, i);
            dy = shift_right(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        case (p32[31:30])
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        c = x;
        s = y;
    endtask

    function automatic logic signed [15:0] round_saturate(longint v);
        longint r;
        r = shift_right(v + (longint'(1) << 46), 47);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    task automatic predict_point(input logic [15:0] idx, output t_point p);
        longint unsigned l, k, k1, base, lk;
        longint c1, s1, c2, s2, ph1, ph2;
        l = (arm_q16 > 17'd65536) ? 65536 : arm_q16;
        k = (radius_q16 > 17'd65536) ? 65536 : radius_q16;
        if (idx >= figure_points) begin
            p = '{x: '0, y: '0, beyond: 1'b1};
            return;
        end
        if (k == 0) k = 1;
        k1 = 65536 - k;
        base = idx * turn_count;
        ph1 = turn_fraction(base, figure_points);
        ph2 = turn_fraction(base * k1, longint'(figure_points) * k);
        rotate_phase(ph1, c1, s1);
        rotate_phase(ph2, c2, s2);
        lk = l * k;
        p.x = round_saturate(longint'(k1) * c1 * 65536 + longint'(lk) * c2);
        p.y = round_saturate(longint'(k1) * s1 * 65536 - longint'(lk) * s2);
        p.beyond = 1'b0;
    endtask

    // valid stays high into the next item; idling or draining drops it
    task automatic send_point(input logic [15:0] idx);
        t_point p;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_point(idx, p);
        pending_points.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline;
        i_valid <= 1'b0;
        while (pending_points.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg_index idx, input logic [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ARM_RATIO:    arm_q16 = val;
            REG_RADIUS_RATIO: radius_q16 = val;
            REG_ROTATIONS:    turn_count = val[7:0];
            REG_POINT_COUNT:  figure_points = val[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [16:0] l, input logic [16:0] k,
                             input logic [7:0] rot, input logic [15:0] cnt);
        drain_pipeline();
        write_register(REG_ARM_RATIO, l);
        write_register(REG_RADIUS_RATIO, k);
        write_register(REG_ROTATIONS, {9'd0, rot});
        write_register(REG_POINT_COUNT, {1'b0, cnt});
    endtask

    task automatic test_directed;
        send_point(16'd0);
        send_point(16'd1);
        send_point(16'd499);
        send_point(16'd500);
        send_point(16'hFFFF);
        send_point(16'h5555);
        configure(17'd65536, 17'd65536, 8'd255, 16'd65535);
        send_point(16'd65534);
        send_point(16'hFFFF);
        send_point(16'd12345);
        configure(17'h1FFFF, 17'h1FFFF, 8'd1, 16'd1);
        send_point(16'd0);
        send_point(16'd1);
        // zero radius ratio and zero rotations
        configure(17'd0, 17'd0, 8'd0, 16'd8);
        send_point(16'd3);
        send_point(16'd7);
        configure(17'd65535, 17'd1, 8'd255, 16'd7);
        for (int i = 0; i < 7; i++) send_point(16'(i));
        // zero point count flags every index
        configure(17'd1000, 17'd30000, 8'd3, 16'd0);
        send_point(16'd0);
        send_point(16'haaaa);
    endtask

    task automatic test_random_figures(input int sender_pct, input int receiver_pct,
                                       input int items);
        logic [15:0] cnt;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int n = 0; n < items; n += 100) begin
            cnt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
            configure(17'($urandom_range(65536 + 200)), 17'($urandom_range(65536)),
                      8'($urandom_range(1, 255)), cnt);
            for (int i = 0; i < 100; i++)
                send_point($urandom_range(9) == 0 ? 16'($urandom) :
                           16'($urandom_range(cnt)));
        end
    endtask

    task automatic test_back_pressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 3 * PIPE_DEPTH;
        repeat (2 * PIPE_DEPTH) send_point(16'($urandom_range(figure_points)));
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && (i_valid && o_ready || o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected point item");
            end else begin
                e = pending_points.pop_front();
                if (e.x !== o_x_coord || e.y !== o_y_coord
                        || e.beyond !== o_index_beyond_count) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("point mismatch: exp x=%0d y=%0d f=%0b got x=%0d y=%0d f=%0b",
                                 e.x, e.y, e.beyond, o_x_coord, o_y_coord,
                                 o_index_beyond_count);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_point_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_ARM_RATIO;
        i_cfg_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 0;
        timed_out = 1'b0;
        arm_q16 = 17'd19661;
        radius_q16 = 17'd49152;
        turn_count = 8'd10;
        figure_points = 16'd500;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_figures(37, 66, 500);
        test_back_pressure();
        test_random_figures(66, 37, 400);
        test_random_figures(0, 0, 500);
        drain_pipeline();
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/hpg_pkg.sv
rtl/hpg_div_cell.sv
rtl/hpg_cordic_cell.sv
rtl/hypotrochoid_point_generator.sv
verif/hypotrochoid_point_generator_test.sv
